// ===== hw/rtl/mra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mra_pkg: shared types and constants of the meeting room allocator
// meeting and result words, the search token handed along the room cells,
// the room write command and the controller states
// ----------------------------------------------------------------------------
package mra_pkg;

  localparam int TIME_W       = 32;
  localparam int END_W        = 48;
  localparam int COUNT_W      = 32;
  localparam int ROOM_FIELD_W = 4;
  localparam int CFG_W        = 5;

  localparam int ROOMS_DEFAULT = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
  localparam logic [END_W-1:0]   END_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              last_meeting;
  } meeting_word_t;

  typedef struct packed {
    logic [ROOM_FIELD_W-1:0] assigned_room;
    logic [END_W-1:0]        actual_end;
    logic                    batch_done;
    logic [ROOM_FIELD_W-1:0] most_booked_room;
  } result_word_t;

  // running search result carried from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [END_W-1:0]   earliest;
    logic [COUNT_W-1:0] most;
  } pass_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic             en;
    logic             clear;
    logic [END_W-1:0] busy;
  } room_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COUNT,
    ST_FINISH
  } state_t;

endpackage : mra_pkg
`default_nettype wire

// ===== hw/rtl/mra_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mra_cell: one room of the allocator chain
// holds the room's busy-until time and booking count, folds them into the
// passing search token and registers the token for the next cell
// ----------------------------------------------------------------------------
module mra_cell #(
  parameter int ROOMS = mra_pkg::ROOMS_DEFAULT,
  parameter int IDX   = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic [mra_pkg::TIME_W-1:0]            start,
  input  wire mra_pkg::pass_t                        pin,
  input  wire logic [((ROOMS > 1) ? $clog2(ROOMS) : 1)-1:0] pin_free_idx,
  input  wire logic [((ROOMS > 1) ? $clog2(ROOMS) : 1)-1:0] pin_min_idx,
  input  wire logic [((ROOMS > 1) ? $clog2(ROOMS) : 1)-1:0] pin_max_idx,
  output mra_pkg::pass_t                             pout,
  output logic [((ROOMS > 1) ? $clog2(ROOMS) : 1)-1:0] pout_free_idx,
  output logic [((ROOMS > 1) ? $clog2(ROOMS) : 1)-1:0] pout_min_idx,
  output logic [((ROOMS > 1) ? $clog2(ROOMS) : 1)-1:0] pout_max_idx,
  input  wire mra_pkg::room_wr_t                     wr,
  input  wire logic [((ROOMS > 1) ? $clog2(ROOMS) : 1)-1:0] wr_room
);

  localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

  logic [mra_pkg::END_W-1:0]   busy;
  logic [mra_pkg::COUNT_W-1:0] count;

  mra_pkg::pass_t   pass_next;
  logic [IDX_W-1:0] free_next;
  logic [IDX_W-1:0] min_next;
  logic [IDX_W-1:0] max_next;
  logic [mra_pkg::END_W-1:0] start_ext;

  assign start_ext = {{(mra_pkg::END_W - mra_pkg::TIME_W){1'b0}}, start};

  always_comb begin
    pass_next = pin;
    free_next = pin_free_idx;
    min_next  = pin_min_idx;
    max_next  = pin_max_idx;
    if (en) begin
      if (!pin.found && (busy <= start_ext)) begin
        pass_next.found = 1'b1;
        free_next       = ME;
      end
      if (busy < pin.earliest) begin
        pass_next.earliest = busy;
        min_next           = ME;
      end
      if (count > pin.most) begin
        pass_next.most = count;
        max_next       = ME;
      end
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else begin
      pout.valid <= pin.valid;
    end
    pout.found    <= pass_next.found;
    pout.earliest <= pass_next.earliest;
    pout.most     <= pass_next.most;
    pout_free_idx <= free_next;
    pout_min_idx  <= min_next;
    pout_max_idx  <= max_next;
  end

  // room state
  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      busy  <= '0;
      count <= '0;
    end else if (wr.en && (wr_room == ME)) begin
      busy <= wr.busy;
      if (count != mra_pkg::COUNT_MAX) begin
        count <= count + mra_pkg::COUNT_W'(1);
      end
    end
  end

endmodule : mra_cell
`default_nettype wire

// ===== hw/rtl/meeting_room_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// meeting_room_allocator_unit: assigns meetings to rooms
// a chain of room cells searched by a token that moves one room per cycle
// ----------------------------------------------------------------------------
// usage
//   meetings enter on meeting_valid/meeting_ready as one word (start, end,
//   last flag), in order of start time. each meeting gives exactly one
//   result word on result_valid/result_ready: room, actual end time, batch
//   flag and, on the last meeting of a batch, the most-booked room.
//   cfg_wr_en/cfg_wr_data set rooms_in_use (1..ROOMS, 0 acts as 1, larger
//   values act as ROOMS); write it only while the block is idle.
// operation
//   one meeting at a time. a search token walks the whole chain of ROOMS
//   cells, one cell per cycle; when it leaves the last cell the result is
//   captured and the room written, the result is loaded into the output
//   register and the block returns to idle to take the next meeting. the
//   last meeting of a batch walks the chain a second time to find the
//   most-booked room before its result is loaded.
//   a new meeting is taken as soon as the previous result sits in the
//   output register, even while the receiver stalls it; a finished meeting
//   then waits until that register is free.
// reset
//   rst clears all rooms to free with zero bookings and sets rooms_in_use
//   to 16. the last meeting of a batch clears all rooms the same way.
// ----------------------------------------------------------------------------
module meeting_room_allocator_unit #(
  parameter int ROOMS = mra_pkg::ROOMS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        meeting_valid,
  output logic                             meeting_ready,
  input  wire mra_pkg::meeting_word_t      meeting,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output mra_pkg::result_word_t            result,
  input  wire logic                        cfg_wr_en,
  input  wire logic [mra_pkg::CFG_W-1:0]   cfg_wr_data
);

  localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int CNT_W = $clog2(ROOMS + 1);

  // configuration
  logic [mra_pkg::CFG_W-1:0] rooms_in_use;

  // current meeting
  logic [mra_pkg::TIME_W-1:0] start_r;
  logic [mra_pkg::TIME_W-1:0] end_r;
  logic                       last_r;
  logic [CNT_W-1:0]           n_r;
  logic [CNT_W-1:0]           n_next;

  // control
  mra_pkg::state_t state, state_next;
  logic launch;
  logic launch_next;
  logic accept;
  logic capture_search;
  logic capture_count;
  logic load_out;

  // result being built
  logic [IDX_W-1:0]          res_room;
  logic [mra_pkg::END_W-1:0] res_end;
  logic [IDX_W-1:0]          res_most;

  // token chain, position k feeds cell k
  mra_pkg::pass_t   chain     [ROOMS+1];
  logic [IDX_W-1:0] free_chain[ROOMS+1];
  logic [IDX_W-1:0] min_chain [ROOMS+1];
  logic [IDX_W-1:0] max_chain [ROOMS+1];
  logic [ROOMS:0]   tok_valid;
  logic [ROOMS-1:0] cell_en;

  mra_pkg::room_wr_t wr;
  logic [IDX_W-1:0]  wr_room;

  // search outcome at the end of the chain
  logic [IDX_W-1:0]           sel_room;
  logic [mra_pkg::TIME_W-1:0] dur;
  logic [mra_pkg::END_W:0]    delayed_sum;
  logic [mra_pkg::END_W-1:0]  finish;

  assign accept = meeting_valid && meeting_ready;

  // clamp the room count to 1..ROOMS
  always_comb begin
    if (rooms_in_use == '0) begin
      n_next = CNT_W'(1);
    end else if (32'(rooms_in_use) > 32'(ROOMS)) begin
      n_next = CNT_W'(ROOMS);
    end else begin
      n_next = CNT_W'(rooms_in_use);
    end
  end

  // fresh token: nothing free yet, earliest at its ceiling, no bookings
  assign chain[0].valid    = launch;
  assign chain[0].found    = 1'b0;
  assign chain[0].earliest = mra_pkg::END_MAX;
  assign chain[0].most     = '0;
  assign free_chain[0]     = '0;
  assign min_chain[0]      = '0;
  assign max_chain[0]      = '0;

  for (genvar k = 0; k < ROOMS; k++) begin : g_room
    assign cell_en[k]   = (CNT_W'(k) < n_r);
    assign tok_valid[k] = chain[k].valid;

    mra_cell #(
      .ROOMS (ROOMS),
      .IDX   (k)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .en            (cell_en[k]),
      .start         (start_r),
      .pin           (chain[k]),
      .pin_free_idx  (free_chain[k]),
      .pin_min_idx   (min_chain[k]),
      .pin_max_idx   (max_chain[k]),
      .pout          (chain[k+1]),
      .pout_free_idx (free_chain[k+1]),
      .pout_min_idx  (min_chain[k+1]),
      .pout_max_idx  (max_chain[k+1]),
      .wr            (wr),
      .wr_room       (wr_room)
    );
  end
  assign tok_valid[ROOMS] = chain[ROOMS].valid;

  // free room if any, else the one that frees up first with the delay added
  always_comb begin
    sel_room    = chain[ROOMS].found ? free_chain[ROOMS] : min_chain[ROOMS];
    dur         = (end_r > start_r) ? (end_r - start_r) : '0;
    delayed_sum = {1'b0, chain[ROOMS].earliest} + (mra_pkg::END_W + 1)'(dur);
    if (chain[ROOMS].found) begin
      finish = mra_pkg::END_W'(end_r);
    end else if (delayed_sum[mra_pkg::END_W]) begin
      finish = mra_pkg::END_MAX;
    end else begin
      finish = delayed_sum[mra_pkg::END_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    meeting_ready  = 1'b0;
    capture_search = 1'b0;
    capture_count  = 1'b0;
    load_out       = 1'b0;
    wr.en          = 1'b0;
    wr.clear       = 1'b0;
    wr.busy        = finish;
    wr_room        = sel_room;
    unique case (state)
      mra_pkg::ST_IDLE: begin
        meeting_ready = 1'b1;
        if (meeting_valid) begin
          state_next = mra_pkg::ST_SEARCH;
        end
      end
      mra_pkg::ST_SEARCH: begin
        if (chain[ROOMS].valid) begin
          capture_search = 1'b1;
          wr.en          = 1'b1;
          state_next     = last_r ? mra_pkg::ST_COUNT : mra_pkg::ST_FINISH;
        end
      end
      mra_pkg::ST_COUNT: begin
        if (chain[ROOMS].valid) begin
          capture_count = 1'b1;
          state_next    = mra_pkg::ST_FINISH;
        end
      end
      mra_pkg::ST_FINISH: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          wr.clear   = last_r;
          state_next = mra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mra_pkg::ST_IDLE;
      end
    endcase
  end

  // second walk after the booking update of the last meeting
  assign launch_next = accept || (capture_search && last_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      launch       <= 1'b0;
      rooms_in_use <= mra_pkg::CFG_RESET;
      result_valid <= 1'b0;
    end else begin
      launch <= launch_next;
      if (cfg_wr_en) begin
        rooms_in_use <= cfg_wr_data;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= meeting.start_time;
      end_r   <= meeting.end_time;
      last_r  <= meeting.last_meeting;
      n_r     <= n_next;
    end
    if (capture_search) begin
      res_room <= sel_room;
      res_end  <= finish;
    end
    if (capture_count) begin
      res_most <= max_chain[ROOMS];
    end
    if (load_out) begin
      result.assigned_room    <= mra_pkg::ROOM_FIELD_W'(res_room);
      result.actual_end       <= res_end;
      result.batch_done       <= last_r;
      result.most_booked_room <= last_r ? mra_pkg::ROOM_FIELD_W'(res_most) : '0;
    end
  end

  // never more than one token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one search token in the room chain");

  // chain is empty whenever the block waits for a meeting
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == mra_pkg::ST_IDLE) |-> (tok_valid == '0))
    else $error("search token present while idle");

  // a token only reaches the end while a walk is expected
  a_token_expected: assert property (@(posedge clk) disable iff (rst)
    chain[ROOMS].valid |->
      (state == mra_pkg::ST_SEARCH) || (state == mra_pkg::ST_COUNT))
    else $error("search token arrived outside a walk");

  // the room picked is always one of the rooms in use
  a_room_in_use: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (CNT_W'(wr_room) < n_r))
    else $error("booking written to a room outside the count");

  // a finished walk leads to a loaded result or a second walk
  a_walk_follow: assert property (@(posedge clk) disable iff (rst)
    capture_search |=> (state == mra_pkg::ST_COUNT) == (launch && last_r))
    else $error("count walk not started after last meeting");

endmodule : meeting_room_allocator_unit
`default_nettype wire

// ===== sim/room_alloc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_alloc_checker: result checker for the meeting room allocator
// watches the meeting, result and config ports, books each accepted meeting
// into its own room table and compares every result word field by field
// ----------------------------------------------------------------------------
module room_alloc_checker #(
  parameter int ROOMS = mra_pkg::ROOMS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          meeting_valid,
  input  logic                          meeting_ready,
  input  mra_pkg::meeting_word_t        meeting,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  mra_pkg::result_word_t         result,
  input  logic                          cfg_wr_en,
  input  logic [mra_pkg::CFG_W-1:0]     cfg_wr_data,
  output int unsigned                   fail_count,
  output int unsigned                   outstanding
);
  import mra_pkg::*;

  logic [END_W-1:0]   busy_until [ROOMS];
  logic [COUNT_W-1:0] bookings   [ROOMS];
  logic [CFG_W-1:0]   room_count_reg;
  result_word_t       due_results [$];
  result_word_t       want;
  int unsigned        errors;

  function automatic void free_all_rooms();
    int unsigned i;
    for (i = 0; i < ROOMS; i++) begin
      busy_until[i] = '0;
      bookings[i]   = '0;
    end
  endfunction

  // books one meeting and returns the result word it should produce
  function automatic result_word_t allocate_room(input meeting_word_t m);
    result_word_t       r;
    int unsigned        n;
    int unsigned        i;
    int unsigned        pick;
    int unsigned        best;
    logic               hit;
    logic [END_W-1:0]   earliest;
    logic [TIME_W-1:0]  dur;
    logic [END_W:0]     sum;
    n = room_count_reg;
    if (n < 1) n = 1;
    if (n > ROOMS) n = ROOMS;
    r    = '0;
    hit  = 1'b0;
    pick = 0;
    for (i = 0; i < n; i++) begin
      if (!hit && busy_until[i] <= m.start_time) begin
        hit  = 1'b1;
        pick = i;
      end
    end
    if (hit) begin
      r.actual_end = m.end_time;
    end else begin
      // nothing free: earliest finisher, lower index wins a tie
      dur      = (m.end_time > m.start_time) ? m.end_time - m.start_time : '0;
      earliest = busy_until[0];
      for (i = 1; i < n; i++) begin
        if (busy_until[i] < earliest) begin
          earliest = busy_until[i];
          pick     = i;
        end
      end
      sum          = {1'b0, earliest} + dur;
      r.actual_end = sum[END_W] ? END_MAX : sum[END_W-1:0];
    end
    busy_until[pick] = r.actual_end;
    if (bookings[pick] != COUNT_MAX) bookings[pick] = bookings[pick] + 1'b1;
    r.assigned_room = pick[ROOM_FIELD_W-1:0];
    r.batch_done    = m.last_meeting;
    if (m.last_meeting) begin
      best = 0;
      for (i = 1; i < n; i++) begin
        if (bookings[i] > bookings[best]) best = i;
      end
      r.most_booked_room = best[ROOM_FIELD_W-1:0];
      free_all_rooms();
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      room_count_reg = CFG_RESET;
      free_all_rooms();
      due_results.delete();
    end else begin
      if (cfg_wr_en) room_count_reg = cfg_wr_data;
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t ns: result word with none expected, got %h", $time, result);
        end else begin
          want = due_results.pop_front();
          check_field("assigned_room", want.assigned_room, result.assigned_room);
          check_field("actual_end", want.actual_end, result.actual_end);
          check_field("batch_done", want.batch_done, result.batch_done);
          check_field("most_booked_room", want.most_booked_room,
                      result.most_booked_room);
        end
      end
      if (meeting_valid && meeting_ready) due_results.push_back(allocate_room(meeting));
    end
    fail_count  <= errors;
    outstanding <= due_results.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the meeting room allocator
// drives a short directed set of meetings, then random batches of meetings
// under three idle patterns with the room count changed between batches;
// the checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;
  import mra_pkg::*;

  localparam int          ROOMS         = ROOMS_DEFAULT;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT   = 5000;
  // last meeting of a batch walks the chain twice
  localparam int unsigned SETTLE_CYCLES = 2 * ROOMS + 8;
  localparam int unsigned PHASE_ITEMS   = 150;

  logic             clk;
  logic             rst           = 1'b1;
  logic             meeting_valid = 1'b0;
  logic             meeting_ready;
  meeting_word_t    meeting       = '0;
  logic             result_valid;
  logic             result_ready  = 1'b0;
  result_word_t     result;
  logic             cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data   = CFG_RESET;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned quiet_cycles  = 0;
  // percent of cycles each side sits idle
  int unsigned send_idle_pct = 11;
  int unsigned take_idle_pct = 65;

  meeting_room_allocator_unit #(.ROOMS(ROOMS)) uut (
    .clk           (clk),
    .rst           (rst),
    .meeting_valid (meeting_valid),
    .meeting_ready (meeting_ready),
    .meeting       (meeting),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  room_alloc_checker #(.ROOMS(ROOMS)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .meeting_valid (meeting_valid),
    .meeting_ready (meeting_ready),
    .meeting       (meeting),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stalls on the result word
  always @(posedge clk) begin
    result_ready <= !rst && ($urandom_range(99, 0) >= take_idle_pct);
  end

  // watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if ((meeting_valid && meeting_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[meeting_room_allocator_unit] ERROR");
      $finish;
    end
  end

  function automatic meeting_word_t booking(input logic [TIME_W-1:0] s,
                                            input logic [TIME_W-1:0] e,
                                            input logic l);
    booking.start_time   = s;
    booking.end_time     = e;
    booking.last_meeting = l;
  endfunction

  // offer one meeting word; valid stays up across back-to-back words and is
  // only lowered when a gap is taken
  task automatic send_meeting(input meeting_word_t w);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      meeting_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    meeting       <= w;
    meeting_valid <= 1'b1;
    do @(posedge clk); while (!meeting_ready);
  endtask

  // stop offering and wait until every expected result word has come back
  task automatic wait_drained();
    meeting_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // room count may only change while the block sits idle
  task automatic set_room_count(input logic [CFG_W-1:0] n);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // one batch: start times mostly nondecreasing with short steps so rooms
  // fill up and delays happen; a few words carry odd or reversed times
  task automatic run_batch(input int unsigned count);
    meeting_word_t     m;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] span;
    int unsigned       k;
    t = ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(1000, 0);
    for (k = 0; k < count; k++) begin
      case ($urandom_range(19, 0))
        0: begin
          // start out of order, no tracking of it
          m.start_time = $urandom;
        end
        1, 2: begin
          m.start_time = t;
        end
        default: begin
          span         = $urandom_range(30, 0);
          m.start_time = (t > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : t + span;
          t            = m.start_time;
        end
      endcase
      case ($urandom_range(19, 0))
        0:       m.end_time = $urandom;
        1:       m.end_time = m.start_time;                      // zero length
        2:       m.end_time = m.start_time - $urandom_range(50, 1); // ends before start
        3:       m.end_time = 32'hFFFF_FFFF;
        default: begin
          span       = $urandom_range(200, 1);
          m.end_time = (m.start_time > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF
                                                             : m.start_time + span;
        end
      endcase
      m.last_meeting = (k == count - 1);
      send_meeting(m);
    end
  endtask

  initial begin
    int unsigned      phase_no;
    int unsigned      left;
    int unsigned      chunk;
    logic [CFG_W-1:0] rooms_pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset room count of 16; zero-length meeting on a free room, then the
    // widest meeting, then a last word naming the most-booked room
    send_meeting(booking(32'd0, 32'd0, 1'b0));
    send_meeting(booking(32'd0, 32'hFFFF_FFFF, 1'b0));
    send_meeting(booking(32'd5, 32'd10, 1'b1));

    // count of zero acts as one room: every overlap is delayed, including
    // meetings whose end is at or before their start
    set_room_count(5'd0);
    send_meeting(booking(32'd100, 32'd200, 1'b0));
    send_meeting(booking(32'd150, 32'd150, 1'b0));
    send_meeting(booking(32'd160, 32'd100, 1'b0));
    send_meeting(booking(32'd170, 32'hFFFF_FFFF, 1'b0));
    send_meeting(booking(32'd200, 32'd300, 1'b1));

    // count above the table acts as all rooms; extreme and reversed starts
    set_room_count(5'd31);
    send_meeting(booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_meeting(booking(32'hFFFF_FFFF, 32'd0, 1'b0));
    send_meeting(booking(32'd7, 32'd9, 1'b1));

    // three rooms filled, then delays with tied finish times
    set_room_count(5'd3);
    send_meeting(booking(32'd10, 32'd50, 1'b0));
    send_meeting(booking(32'd10, 32'd50, 1'b0));
    send_meeting(booking(32'd10, 32'd50, 1'b0));
    send_meeting(booking(32'd20, 32'd30, 1'b0));
    send_meeting(booking(32'd20, 32'd25, 1'b0));

    // widen mid-batch: rooms beyond three kept their state and now join
    set_room_count(5'd16);
    send_meeting(booking(32'd30, 32'd40, 1'b0));
    send_meeting(booking(32'd31, 32'd45, 1'b1));

    // random batches under three idle patterns
    for (phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin
          send_idle_pct = 11;
          take_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          take_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      left = PHASE_ITEMS;
      while (left > 0) begin
        chunk = $urandom_range(30, 1);
        if (chunk > left) chunk = left;
        if ($urandom_range(1, 0) == 1) begin
          case ($urandom_range(5, 0))
            0:       rooms_pick = 5'd0;
            1:       rooms_pick = 5'd1;
            2:       rooms_pick = 5'd16;
            3:       rooms_pick = 5'd31;
            4:       rooms_pick = $urandom_range(15, 2);
            default: rooms_pick = $urandom_range(30, 17);
          endcase
          set_room_count(rooms_pick);
        end
        run_batch(chunk);
        left -= chunk;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[meeting_room_allocator_unit] OK");
    end else begin
      $display("[meeting_room_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mra_pkg.sv
hw/rtl/mra_cell.sv
hw/rtl/meeting_room_allocator_unit.sv
sim/room_alloc_checker.sv
sim/tb_top.sv
